// ----- design/grla_pkg.sv -----
// Shared types and constants for the grid ray light attenuation block.
package grla_pkg;

   localparam int CoordW  = 8;
   localparam int TileW   = 6;
   localparam int IntenW  = 6;
   localparam int LevelW  = 6;
   localparam int TenthsW = 12;
   localparam int CsrW    = 10;

   localparam logic [LevelW-1:0] LevelMax = 6'd50;

   // reset values of the cost registers, in tenths
   localparam logic [9:0] SolidCostRst    = 10'd200;
   localparam logic [7:0] StraightCostRst = 8'd10;
   localparam logic [7:0] DiagCostRst     = 8'd14;
   localparam logic [9:0] EntryBonusRst   = 10'd100;

   typedef logic signed [TenthsW-1:0] tenths_type;

   typedef enum logic [1:0] {
      CSR_SOLID_COST    = 2'd0,
      CSR_STRAIGHT_COST = 2'd1,
      CSR_DIAG_COST     = 2'd2,
      CSR_ENTRY_BONUS   = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_TRACE = 1'b1
   } action_type;

   // flags of the line point whose tile is being looked up
   typedef struct packed {
      logic in_map;
      logic at_end;
      logic diag;
   } walk_point_type;

endpackage

// ----- design/grid_ray_light_attenuation.sv -----
// Top level: tile map RAM, ray walk control, intensity bookkeeping and result register.
//
// A write item sets one bit of the tile map. A trace item walks the Bresenham line
// one point per cycle, each point costing one read of the tile map RAM, and holds
// req_ready low until it finishes; its line has N points (N = max(|dx|,|dy|) + 1, at
// most 256, fewer when the light dies or is blocked), and a trace whose start equals
// its end skips the walk. The next item is taken while a result still waits on
// rsp_ready. After reset the map is swept to solid, one tile a cycle, over all
// MAP_TILES_X * MAP_TILES_Y tiles (4096 by default), with req_ready low; cost
// registers can be written at any time the block is idle, including during the sweep.
module grid_ray_light_attenuation import grla_pkg::*; #(
   parameter int MAP_TILES_X = 64,
   parameter int MAP_TILES_Y = 64,
   parameter int TILE_SIZE   = 4
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [TileW-1:0]  req_tile_x,
   input  logic [TileW-1:0]  req_tile_y,
   input  logic              req_tile_open,
   input  logic [CoordW-1:0] req_start_x,
   input  logic [CoordW-1:0] req_start_y,
   input  logic [CoordW-1:0] req_end_x,
   input  logic [CoordW-1:0] req_end_y,
   input  logic [IntenW-1:0] req_intensity,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [LevelW-1:0] rsp_light_level,

   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CsrW-1:0]   csr_wdata
);

   localparam int Depth = MAP_TILES_X * MAP_TILES_Y;
   localparam int AddrW = $clog2(Depth);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [AddrW-1:0]  clr_ff, clr_in;
   tenths_type        level_ff, level_in;
   tenths_type        fin_ff, fin_in;
   logic              open_ff, open_in;
   logic              first_ff, first_in;
   logic              pend_ff, pend_in;
   walk_point_type    ptq_ff, ptq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LevelW-1:0] rsp_level_ff, rsp_level_in;

   logic [9:0] solid_cost_ff, bonus_ff;
   logic [7:0] straight_cost_ff, diag_cost_ff;

   logic              req_fire, is_trace, same_point;
   logic              ram_wr_en, ram_wr_data, ram_rd_data, walk_load;
   logic [AddrW-1:0]  ram_wr_addr, tile_addr, walk_addr;
   walk_point_type    walk_pt;
   tenths_type        start_tenths;

   logic              here, open_cur, kill, gain;
   tenths_type        lvl1, step_cost;
   logic              stop;
   logic [16:0]       div_prod;
   logic [LevelW-1:0] level_out;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign is_trace   = (req_action == ACT_TRACE);
   assign same_point = (req_start_x == req_end_x) && (req_start_y == req_end_y);
   assign walk_load  = req_fire && is_trace;

   // whole units to tenths: i*8 + i*2
   assign start_tenths = tenths_type'({3'b000, req_intensity, 3'b000})
                       + tenths_type'({5'b00000, req_intensity, 1'b0});

   assign tile_addr = AddrW'(32'(req_tile_y) * 32'(MAP_TILES_X) + 32'(req_tile_x));

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = tile_addr;
      ram_wr_data = req_tile_open;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = 1'b0;
      end else if (req_fire && !is_trace) begin
         // drop writes that fall outside a narrower map
         ram_wr_en = (11'(req_tile_x) < 11'(MAP_TILES_X))
                  && (11'(req_tile_y) < 11'(MAP_TILES_Y));
      end
   end

   grla_ram #(
      .WIDTH (1),
      .DEPTH (Depth)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == ST_WALK),
      .rd_addr (walk_addr),
      .rd_data (ram_rd_data)
   );

   grla_walk #(
      .MAP_TILES_X (MAP_TILES_X),
      .MAP_TILES_Y (MAP_TILES_Y),
      .TILE_SIZE   (TILE_SIZE)
   ) u_walk (
      .clock      (clock),
      .load       (walk_load),
      .advance    (state_ff == ST_WALK),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .point_addr (walk_addr),
      .point      (walk_pt)
   );

   // evaluate the point whose tile just came back from the RAM
   assign here     = ram_rd_data && ptq_ff.in_map;
   assign open_cur = first_ff ? here : open_ff;
   assign kill     = open_cur && !here;
   assign gain     = !open_cur && here;
   assign lvl1     = level_ff + (gain ? tenths_type'({2'b00, bonus_ff}) : 12'sd0);
   assign stop     = kill || ptq_ff.at_end || (lvl1 <= 12'sd0);

   always_comb begin
      if (!(open_cur || gain)) begin
         step_cost = tenths_type'({2'b00, solid_cost_ff});
      end else if (ptq_ff.diag) begin
         step_cost = tenths_type'({4'b0000, diag_cost_ff});
      end else begin
         step_cost = tenths_type'({4'b0000, straight_cost_ff});
      end
   end

   // tenths to whole units below 500: multiply by 205/2048
   assign div_prod = 17'(fin_ff[8:0]) * 17'd205;
   always_comb begin
      if (fin_ff < 12'sd0) begin
         level_out = '0;
      end else if (fin_ff >= 12'sd500) begin
         level_out = LevelMax;
      end else begin
         level_out = div_prod[16:11];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      level_in     = level_ff;
      fin_in       = fin_ff;
      open_in      = open_ff;
      first_in     = first_ff;
      pend_in      = pend_ff;
      ptq_in       = ptq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && is_trace) begin
               if (same_point) begin
                  fin_in   = start_tenths;
                  state_in = ST_FINISH;
               end else begin
                  level_in = start_tenths;
                  first_in = 1'b1;
                  pend_in  = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            pend_in = 1'b1;
            ptq_in  = walk_pt;
            if (pend_ff) begin
               first_in = 1'b0;
               open_in  = open_cur || gain;
               level_in = lvl1 - step_cost;
               if (stop) begin
                  fin_in   = kill ? 12'sd0 : lvl1;
                  pend_in  = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_out;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff     <= level_in;
      fin_ff       <= fin_in;
      ptq_ff       <= ptq_in;
      rsp_level_ff <= rsp_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         solid_cost_ff    <= SolidCostRst;
         straight_cost_ff <= StraightCostRst;
         diag_cost_ff     <= DiagCostRst;
         bonus_ff         <= EntryBonusRst;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOLID_COST:    solid_cost_ff    <= csr_wdata;
            CSR_STRAIGHT_COST: straight_cost_ff <= csr_wdata[7:0];
            CSR_DIAG_COST:     diag_cost_ff     <= csr_wdata[7:0];
            CSR_ENTRY_BONUS:   bonus_ff         <= csr_wdata;
            default:           solid_cost_ff    <= solid_cost_ff;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_light_level = rsp_level_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside the finish step");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= LevelMax)
      else $error("light level above its clamp");

   a_map_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE) || (state_ff == ST_CLEAR))
      else $error("tile map written during a trace");

   a_first_eval_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && pend_ff |-> $past(state_ff) == ST_WALK)
      else $error("tile evaluated without a lookup issued");

endmodule

// ----- design/grla_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module grla_ram #(
   parameter int  WIDTH = 1,
   parameter int  DEPTH = 4096,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/grla_walk.sv -----
// Bresenham line stepper: holds the current point and forms its tile address.
module grla_walk import grla_pkg::*; #(
   parameter int  MAP_TILES_X = 64,
   parameter int  MAP_TILES_Y = 64,
   parameter int  TILE_SIZE   = 4,
   localparam int AddrW       = $clog2(MAP_TILES_X * MAP_TILES_Y)
) (
   input  logic              clock,
   input  logic              load,
   input  logic              advance,
   input  logic [CoordW-1:0] start_x,
   input  logic [CoordW-1:0] start_y,
   input  logic [CoordW-1:0] end_x,
   input  logic [CoordW-1:0] end_y,
   output logic [AddrW-1:0]  point_addr,
   output walk_point_type    point
);

   // reciprocal of the tile size, rounded up; exact for 8-bit coordinates
   localparam int Recip = (65536 + TILE_SIZE - 1) / TILE_SIZE;
   localparam int ProdW = CoordW + 17;

   logic [CoordW-1:0] x_ff, y_ff, x1_ff, y1_ff, dx_ff, dy_ff;
   logic              sx_neg_ff, sy_neg_ff;
   logic signed [10:0] err_ff;

   logic [CoordW-1:0]  dx_ld, dy_ld;
   logic signed [10:0] err_ld;
   logic signed [11:0] e2;
   logic               mx, my, at_end;
   logic signed [10:0] err_step;
   logic [CoordW-1:0]  x_step, y_step;
   logic [ProdW-1:0]   qx, qy;
   logic [CoordW-1:0]  tx, ty;

   assign dx_ld  = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
   assign dy_ld  = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
   assign err_ld = $signed({3'b000, dx_ld}) - $signed({3'b000, dy_ld});

   assign e2 = {err_ff, 1'b0};
   assign my = e2 < $signed({4'b0000, dx_ff});
   assign mx = e2 > -$signed({4'b0000, dy_ff});

   assign err_step = err_ff + (my ? $signed({3'b000, dx_ff}) : 11'sd0)
                            - (mx ? $signed({3'b000, dy_ff}) : 11'sd0);
   assign x_step = mx ? (sx_neg_ff ? x_ff - 8'd1 : x_ff + 8'd1) : x_ff;
   assign y_step = my ? (sy_neg_ff ? y_ff - 8'd1 : y_ff + 8'd1) : y_ff;

   assign at_end = (x_ff == x1_ff) && (y_ff == y1_ff);

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff      <= start_x;
         y_ff      <= start_y;
         x1_ff     <= end_x;
         y1_ff     <= end_y;
         dx_ff     <= dx_ld;
         dy_ff     <= dy_ld;
         sx_neg_ff <= !(start_x < end_x);
         sy_neg_ff <= !(start_y < end_y);
         err_ff    <= err_ld;
      end else if (advance && !at_end) begin
         x_ff   <= x_step;
         y_ff   <= y_step;
         err_ff <= err_step;
      end
   end

   // point to tile: multiply by the reciprocal, keep the whole part
   assign qx = ProdW'(x_ff) * ProdW'(Recip);
   assign qy = ProdW'(y_ff) * ProdW'(Recip);
   assign tx = qx[CoordW+15:16];
   assign ty = qy[CoordW+15:16];

   assign point_addr = AddrW'(32'(ty) * 32'(MAP_TILES_X) + 32'(tx));

   assign point.in_map = (11'(tx) < 11'(MAP_TILES_X)) && (11'(ty) < 11'(MAP_TILES_Y));
   assign point.at_end = at_end;
   assign point.diag   = mx && my;

endmodule

// ----- sim/grid_ray_light_attenuation_tb.sv -----
// Self-checking testbench for grid_ray_light_attenuation: tile writes and ray traces.
module grid_ray_light_attenuation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import grla_pkg::*;

   localparam int MapTiles    = 64;
   localparam int TileSize    = 4;
   localparam int NumPhases   = 7;
   localparam int PhaseItems  = 105;
   localparam int DrainCycles = 300;
   localparam int LongHold    = 2000;
   localparam int CycleLimit  = 1500000;

   typedef struct {
      action_type        action;
      logic [TileW-1:0]  tile_x;
      logic [TileW-1:0]  tile_y;
      logic              tile_open;
      logic [CoordW-1:0] start_x;
      logic [CoordW-1:0] start_y;
      logic [CoordW-1:0] end_x;
      logic [CoordW-1:0] end_y;
      logic [IntenW-1:0] intensity;
   } light_req_type;

   class light_scoreboard_type;
      bit                tile_map [MapTiles*MapTiles];
      int                solid_cost;
      int                straight_cost;
      int                diag_cost;
      int                bonus;
      logic [LevelW-1:0] level_q [$];
      int                mismatches;

      function new();
         foreach (tile_map[i]) tile_map[i] = 1'b0;
         solid_cost    = SolidCostRst;
         straight_cost = StraightCostRst;
         diag_cost     = DiagCostRst;
         bonus         = EntryBonusRst;
         mismatches    = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CsrW-1:0] value);
         case (idx)
            CSR_SOLID_COST:    solid_cost    = value[9:0];
            CSR_STRAIGHT_COST: straight_cost = value[7:0];
            CSR_DIAG_COST:     diag_cost     = value[7:0];
            CSR_ENTRY_BONUS:   bonus         = value[9:0];
            default: ;
         endcase
      endfunction

      function bit open_at(int px, int py);
         int tx;
         int ty;
         tx = px / TileSize;
         ty = py / TileSize;
         if (tx < 0 || ty < 0 || tx >= MapTiles || ty >= MapTiles) return 1'b0;
         return tile_map[ty*MapTiles + tx];
      endfunction

      // Walk the line point by point and queue the light level left at the end.
      function void note_request(light_req_type r);
         int   x0, y0, x1, y1, dx, dy, sx, sy, err, e2, tenths;
         bit   in_open, here, mx, my, done;
         logic [LevelW-1:0] level;
         if (r.action == ACT_WRITE) begin
            tile_map[int'(r.tile_y)*MapTiles + int'(r.tile_x)] = r.tile_open;
            return;
         end
         x0 = r.start_x;
         y0 = r.start_y;
         x1 = r.end_x;
         y1 = r.end_y;
         tenths = r.intensity;
         if (x0 == x1 && y0 == y1) begin
            level = (tenths > int'(LevelMax)) ? LevelMax : LevelW'(tenths);
         end else begin
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            tenths = tenths * 10;
            in_open = open_at(x0, y0);
            done = 1'b0;
            level = '0;
            while (!done) begin
               here = open_at(x0, y0);
               if (in_open && !here) begin
                  level = '0;
                  done = 1'b1;
               end else begin
                  if (!in_open && here) begin
                     in_open = 1'b1;
                     tenths += bonus;
                  end
                  if ((x0 == x1 && y0 == y1) || tenths <= 0) begin
                     if (tenths < 0) level = '0;
                     else if (tenths >= int'(LevelMax) * 10) level = LevelMax;
                     else level = LevelW'(tenths / 10);
                     done = 1'b1;
                  end else begin
                     mx = 1'b0;
                     my = 1'b0;
                     e2 = 2 * err;
                     if (e2 < dx) begin
                        err += dx;
                        y0 += sy;
                        my = 1'b1;
                     end
                     if (e2 > -dy) begin
                        err -= dy;
                        x0 += sx;
                        mx = 1'b1;
                     end
                     if (!in_open) tenths -= solid_cost;
                     else if (mx && my) tenths -= diag_cost;
                     else tenths -= straight_cost;
                  end
               end
            end
         end
         level_q.push_back(level);
      endfunction

      function void check_level(logic [LevelW-1:0] got);
         logic [LevelW-1:0] want;
         if (level_q.size() == 0) begin
            $error("light_level: no result expected, got %0d", got);
            mismatches++;
            return;
         end
         want = level_q.pop_front();
         if (got !== want) begin
            $error("light_level: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction

      function int pending();
         return level_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_action;
   logic [TileW-1:0]  req_tile_x;
   logic [TileW-1:0]  req_tile_y;
   logic              req_tile_open;
   logic [CoordW-1:0] req_start_x;
   logic [CoordW-1:0] req_start_y;
   logic [CoordW-1:0] req_end_x;
   logic [CoordW-1:0] req_end_y;
   logic [IntenW-1:0] req_intensity;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [LevelW-1:0] rsp_light_level;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [CsrW-1:0]   csr_wdata;

   light_scoreboard_type sb = new();
   bit                   no_idle;
   bit                   long_hold_req;
   bit                   long_hold_done;
   int                   cycle_count;

   grid_ray_light_attenuation dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_tile_x      (req_tile_x),
      .req_tile_y      (req_tile_y),
      .req_tile_open   (req_tile_open),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_intensity   (req_intensity),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_light_level (rsp_light_level),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic light_req_type rand_req();
      light_req_type r;
      r.action    = $urandom_range(0, 1) ? ACT_TRACE : ACT_WRITE;
      r.tile_x    = TileW'($urandom_range(0, 63));
      r.tile_y    = TileW'($urandom_range(0, 63));
      r.tile_open = 1'($urandom_range(0, 1));
      r.start_x   = CoordW'($urandom_range(0, 255));
      r.start_y   = CoordW'($urandom_range(0, 255));
      r.end_x     = CoordW'($urandom_range(0, 255));
      r.end_y     = CoordW'($urandom_range(0, 255));
      r.intensity = IntenW'($urandom_range(0, 63));
      return r;
   endfunction

   function automatic light_req_type mk_write(int tx, int ty, bit open_tile);
      light_req_type r;
      r = rand_req();
      r.action    = ACT_WRITE;
      r.tile_x    = TileW'(tx);
      r.tile_y    = TileW'(ty);
      r.tile_open = open_tile;
      return r;
   endfunction

   function automatic light_req_type mk_trace(int sx, int sy, int ex, int ey, int inten);
      light_req_type r;
      r = rand_req();
      r.action    = ACT_TRACE;
      r.start_x   = CoordW'(sx);
      r.start_y   = CoordW'(sy);
      r.end_x     = CoordW'(ex);
      r.end_y     = CoordW'(ey);
      r.intensity = IntenW'(inten);
      return r;
   endfunction

   // Offer one beat and hold it until accepted; returns at the accepting edge.
   task automatic send_beat(input light_req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= r.action;
      req_tile_x    <= r.tile_x;
      req_tile_y    <= r.tile_y;
      req_tile_open <= r.tile_open;
      req_start_x   <= r.start_x;
      req_start_y   <= r.start_y;
      req_end_x     <= r.end_x;
      req_end_y     <= r.end_y;
      req_intensity <= r.intensity;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic program_costs(input logic [CsrW-1:0] solid, input logic [CsrW-1:0] straight,
                                input logic [CsrW-1:0] diag, input logic [CsrW-1:0] entry);
      write_csr(CSR_SOLID_COST, solid);
      write_csr(CSR_STRAIGHT_COST, straight);
      write_csr(CSR_DIAG_COST, diag);
      write_csr(CSR_ENTRY_BONUS, entry);
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait for every pending level, then let a trailing walk finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin : result_side
      int hold_cnt;
      hold_cnt = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) sb.check_level(rsp_light_level);
         if (long_hold_req && !long_hold_done) begin
            hold_cnt = LongHold;
            long_hold_done = 1'b1;
         end else if (hold_cnt == 0 && $urandom_range(0, 7) == 0) begin
            hold_cnt = pick_gap();
         end
         if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
            hold_cnt--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin : request_side
      light_req_type r;
      int            roll;
      no_idle        = 1'b0;
      long_hold_req  = 1'b0;
      long_hold_done = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= ACT_WRITE;
      req_tile_x    <= '0;
      req_tile_y    <= '0;
      req_tile_open <= 1'b0;
      req_start_x   <= '0;
      req_start_y   <= '0;
      req_end_x     <= '0;
      req_end_y     <= '0;
      req_intensity <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_SOLID_COST;
      csr_wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      program_costs(SolidCostRst, CsrW'(StraightCostRst), CsrW'(DiagCostRst), EntryBonusRst);

      // open a 2x2 block at the origin and the single far corner tile, then open and close tile (63,0)
      send_beat(mk_write(0, 0, 1'b1));
      send_beat(mk_write(1, 0, 1'b1));
      send_beat(mk_write(0, 1, 1'b1));
      send_beat(mk_write(1, 1, 1'b1));
      send_beat(mk_write(63, 63, 1'b1));
      send_beat(mk_write(63, 0, 1'b1));
      send_beat(mk_write(63, 0, 1'b0));
      // start on the end point
      send_beat(mk_trace(5, 5, 5, 5, 63));
      send_beat(mk_trace(255, 255, 255, 255, 0));
      send_beat(mk_trace(0, 0, 0, 0, 37));
      no_idle = 1'b1;
      send_beat(mk_trace(0, 0, 7, 7, 20));
      send_beat(mk_trace(0, 0, 7, 0, 20));
      // solid into open gets the bonus, open into solid blocks
      send_beat(mk_trace(12, 1, 1, 1, 40));
      send_beat(mk_trace(1, 1, 12, 1, 63));
      // ends below zero
      send_beat(mk_trace(20, 20, 21, 20, 1));
      no_idle = 1'b0;
      send_beat(mk_trace(0, 0, 255, 255, 63));
      send_beat(mk_trace(255, 0, 0, 255, 63));
      send_beat(mk_trace(8, 0, 2, 0, 63));
      send_beat(mk_trace(3, 3, 0, 0, 0));
      send_beat(mk_trace(252, 252, 255, 255, 5));
      send_beat(mk_trace(255, 255, 240, 250, 63));

      for (int phase = 0; phase < NumPhases; phase++) begin
         settle();
         case (phase)
            0: program_costs('0, '0, '0, '0);
            1: program_costs(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
            3: program_costs(CsrW'(0), CsrW'(1), CsrW'(2), CsrW'(0));
            6: program_costs(SolidCostRst, CsrW'(StraightCostRst), CsrW'(DiagCostRst),
                             EntryBonusRst);
            default: program_costs(CsrW'($urandom_range(0, 1023)),
                                   CsrW'($urandom_range(0, 1023)),
                                   CsrW'($urandom_range(0, 1023)),
                                   CsrW'($urandom_range(0, 1023)));
         endcase
         no_idle = (phase == 3);
         for (int n = 0; n < PhaseItems; n++) begin
            r = rand_req();
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
               r.action = ACT_WRITE;
               // keep most writes in the window the traces walk through
               if ($urandom_range(0, 99) < 80) begin
                  r.tile_x    = TileW'($urandom_range(0, 15));
                  r.tile_y    = TileW'($urandom_range(0, 15));
                  r.tile_open = ($urandom_range(0, 99) < 80);
               end
            end else begin
               r.action = ACT_TRACE;
               if (roll < 75) begin
                  r.start_x = CoordW'($urandom_range(0, 63));
                  r.start_y = CoordW'($urandom_range(0, 63));
                  r.end_x   = CoordW'($urandom_range(0, 63));
                  r.end_y   = CoordW'($urandom_range(0, 63));
               end else if (roll < 85) begin
                  r.end_x = r.start_x;
                  r.end_y = r.start_y;
               end
            end
            if (phase == 2 && n == 10) long_hold_req = 1'b1;
            send_beat(r);
         end
      end

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
